### rtl/odo_pkg.sv
// shared types, constants and the arctangent table for the odometry block
package odo_pkg;

    localparam int CFG_W    = 24;
    localparam int IDX_W    = 5;
    localparam int MAX_STEP = 32;
    localparam int DIV_W    = 58;

    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [34:0] TWO_PI_Q28  = 35'sd1686629713;
    localparam logic signed [57:0] GAIN_Q30    = 58'sd652032874;

    // register map, indexed by paddr[2]
    typedef enum logic {
        REG_DPT = 1'b0,
        REG_WB  = 1'b1
    } reg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL_L,
        S_MUL_R,
        S_MUL_WB,
        S_SETUP,
        S_NORM,
        S_VEC,
        S_HEAD,
        S_ROT_SET,
        S_ROT,
        S_MXH,
        S_MXL,
        S_MYH,
        S_MYL,
        S_MYF,
        S_MYA,
        S_WAIT_DIV,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        MUL_LEFT,
        MUL_RIGHT,
        MUL_XHI,
        MUL_XLO,
        MUL_YHI,
        MUL_YLO
    } mul_sel_t;

    typedef struct packed {
        logic             load_in;
        logic             dl_load;
        logic             dr_load;
        logic             setup;
        logic             norm_shr;
        logic             norm_shl;
        logic             vec_step;
        logic             head_update;
        logic             rot_init;
        logic             rot_step;
        mul_sel_t         mul_sel;
        logic             part_load;
        logic             part_add;
        logic             acc_x;
        logic             acc_y;
        logic             out_load;
        logic [IDX_W-1:0] step_idx;
    } cmd_t;

    typedef struct packed {
        logic y_zero;
        logic norm_big;
        logic norm_small;
        logic div_done;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic signed [31:0] left_speed;
        logic signed [31:0] right_speed;
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic signed [31:0] heading;
        logic               zero_interval;
    } res_t;

    // atan(2^-i) in 2^-30 rad, truncated up to i = 26 and rounded above it
    function automatic logic [29:0] atan_q30(input logic [IDX_W-1:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            5'd24: v = 30'd63;
            5'd25: v = 30'd31;
            5'd26: v = 30'd15;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/odo_in_if.sv
// input channel: encoder counts and timestamp
interface odo_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic        [31:0] time_ms;

    modport source (output valid, left_count, right_count, time_ms, input ready);
    modport sink   (input valid, left_count, right_count, time_ms, output ready);
endinterface

### rtl/odo_out_if.sv
// output channel: wheel speeds and pose
interface odo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_speed;
    logic signed [31:0] right_speed;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [31:0] heading;
    logic               zero_interval;

    modport source (output valid, left_speed, right_speed, pos_x, pos_y, heading,
                    zero_interval, input ready);
    modport sink   (input valid, left_speed, right_speed, pos_x, pos_y, heading,
                    zero_interval, output ready);
endinterface

### rtl/odo_div.sv
// two-lane restoring divider, one quotient bit per cycle
module odo_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [odo_pkg::DIV_W-1:0]      dividend_l,
    input  logic [odo_pkg::DIV_W-1:0]      dividend_r,
    input  logic [31:0]                    divisor,
    output logic                           done,
    output logic [odo_pkg::DIV_W-1:0]      quot_l,
    output logic [odo_pkg::DIV_W-1:0]      quot_r
);
    localparam int CNT_W = $clog2(odo_pkg::DIV_W + 1);

    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic [31:0]                div_reg;
    logic [31:0]                rem_reg  [2];
    logic [31:0]                rem_next [2];
    logic [odo_pkg::DIV_W-1:0]  qm_reg   [2];
    logic [odo_pkg::DIV_W-1:0]  qm_next  [2];
    logic [32:0]                rem_sh   [2];
    logic                       qbit     [2];

    // one shift-compare-subtract per lane
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            rem_sh[k] = {rem_reg[k], qm_reg[k][odo_pkg::DIV_W-1]};
            qbit[k]   = (rem_sh[k] >= {1'b0, div_reg});
            if (qbit[k])
            begin
                rem_next[k] = 32'(rem_sh[k] - {1'b0, div_reg});
            end
            else
            begin
                rem_next[k] = rem_sh[k][31:0];
            end
            qm_next[k] = {qm_reg[k][odo_pkg::DIV_W-2:0], qbit[k]};
        end
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(odo_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand and remainder registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg    <= divisor;
            rem_reg[0] <= '0;
            rem_reg[1] <= '0;
            qm_reg[0]  <= dividend_l;
            qm_reg[1]  <= dividend_r;
        end
        else if (busy_reg)
        begin
            rem_reg[0] <= rem_next[0];
            rem_reg[1] <= rem_next[1];
            qm_reg[0]  <= qm_next[0];
            qm_reg[1]  <= qm_next[1];
        end
    end

    assign done   = !busy_reg && !start;
    assign quot_l = qm_reg[0];
    assign quot_r = qm_reg[1];
endmodule

### rtl/odo_ctrl.sv
// sequencer for the odometry datapath
module odo_ctrl #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  odo_pkg::status_t  status,
    output odo_pkg::cmd_t     cmd
);
    localparam int STEPS = (CORDIC_STEPS > odo_pkg::MAX_STEP) ? odo_pkg::MAX_STEP
                                                              : CORDIC_STEPS;

    odo_pkg::state_t               state_reg, state_next;
    logic [odo_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic                          last;

    assign last = (idx_reg == odo_pkg::IDX_W'(STEPS - 1));

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= odo_pkg::S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.mul_sel  = odo_pkg::MUL_LEFT;
        cmd.step_idx = idx_reg;
        in_ready     = 1'b0;
        case (state_reg)
            odo_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = odo_pkg::S_MUL_L;
                end
            end
            odo_pkg::S_MUL_L:
            begin
                cmd.mul_sel = odo_pkg::MUL_LEFT;
                state_next  = odo_pkg::S_MUL_R;
            end
            odo_pkg::S_MUL_R:
            begin
                cmd.mul_sel = odo_pkg::MUL_RIGHT;
                cmd.dl_load = 1'b1;
                state_next  = odo_pkg::S_MUL_WB;
            end
            odo_pkg::S_MUL_WB:
            begin
                cmd.dr_load = 1'b1;
                state_next  = odo_pkg::S_SETUP;
            end
            odo_pkg::S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = odo_pkg::S_NORM;
            end
            odo_pkg::S_NORM:
            begin
                idx_next = '0;
                if (status.y_zero)
                begin
                    state_next = odo_pkg::S_HEAD;
                end
                else if (status.norm_big)
                begin
                    cmd.norm_shr = 1'b1;
                end
                else if (status.norm_small)
                begin
                    cmd.norm_shl = 1'b1;
                end
                else
                begin
                    state_next = odo_pkg::S_VEC;
                end
            end
            odo_pkg::S_VEC:
            begin
                cmd.vec_step = 1'b1;
                idx_next     = idx_reg + 1'b1;
                if (last)
                begin
                    state_next = odo_pkg::S_HEAD;
                end
            end
            odo_pkg::S_HEAD:
            begin
                cmd.head_update = 1'b1;
                state_next      = odo_pkg::S_ROT_SET;
            end
            odo_pkg::S_ROT_SET:
            begin
                cmd.rot_init = 1'b1;
                idx_next     = '0;
                state_next   = odo_pkg::S_ROT;
            end
            odo_pkg::S_ROT:
            begin
                cmd.rot_step = 1'b1;
                idx_next     = idx_reg + 1'b1;
                if (last)
                begin
                    state_next = odo_pkg::S_MXH;
                end
            end
            odo_pkg::S_MXH:
            begin
                cmd.mul_sel = odo_pkg::MUL_XHI;
                state_next  = odo_pkg::S_MXL;
            end
            odo_pkg::S_MXL:
            begin
                cmd.mul_sel   = odo_pkg::MUL_XLO;
                cmd.part_load = 1'b1;
                state_next    = odo_pkg::S_MYH;
            end
            odo_pkg::S_MYH:
            begin
                cmd.mul_sel  = odo_pkg::MUL_YHI;
                cmd.part_add = 1'b1;
                state_next   = odo_pkg::S_MYL;
            end
            odo_pkg::S_MYL:
            begin
                cmd.mul_sel   = odo_pkg::MUL_YLO;
                cmd.acc_x     = 1'b1;
                cmd.part_load = 1'b1;
                state_next    = odo_pkg::S_MYF;
            end
            odo_pkg::S_MYF:
            begin
                cmd.part_add = 1'b1;
                state_next   = odo_pkg::S_MYA;
            end
            odo_pkg::S_MYA:
            begin
                cmd.acc_y  = 1'b1;
                state_next = odo_pkg::S_WAIT_DIV;
            end
            odo_pkg::S_WAIT_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = odo_pkg::S_OUT;
                end
            end
            odo_pkg::S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = odo_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = odo_pkg::S_IDLE;
            end
        endcase
    end
endmodule

### rtl/odo_datapath.sv
// odometry datapath: differences, multiplier, shared cordic, pose and output register
module odo_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  odo_pkg::cmd_t               cmd,
    output odo_pkg::status_t            status,
    input  logic signed [31:0]          left_count,
    input  logic signed [31:0]          right_count,
    input  logic        [31:0]          time_ms,
    input  logic [odo_pkg::CFG_W-1:0]   dpt,
    input  logic [odo_pkg::CFG_W-1:0]   wheel_base,
    output odo_pkg::res_t               res,
    output logic                        res_valid,
    input  logic                        res_ready
);
    // architectural state
    logic        [31:0] prev_left_reg, prev_right_reg, prev_time_reg;
    logic signed [31:0] theta_now_reg, theta_prev_reg;
    logic signed [47:0] x_acc_reg, y_acc_reg;

    // per-transaction working registers
    logic signed [31:0] ld_reg, rd_reg;
    logic        [31:0] dt_reg;
    logic signed [56:0] dl_reg, dr_reg, dist_reg;
    logic        [63:0] prod_reg;
    logic        [58:0] part_reg;
    logic signed [57:0] cx_reg, cy_reg;
    logic signed [34:0] cz_reg;
    logic               neg_reg;
    logic               out_valid_reg;
    odo_pkg::res_t      out_reg;

    // differences at transaction acceptance
    logic [31:0] rc_neg;
    assign rc_neg = 32'(-right_count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            prev_time_reg  <= '0;
        end
        else if (cmd.load_in)
        begin
            prev_left_reg  <= left_count;
            prev_right_reg <= rc_neg;
            prev_time_reg  <= time_ms;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            ld_reg <= left_count - prev_left_reg;
            rd_reg <= rc_neg - prev_right_reg;
            dt_reg <= time_ms - prev_time_reg;
        end
    end

    // magnitudes feeding the multiplier
    logic [31:0] ld_mag, rd_mag;
    logic [55:0] dist_mag;
    logic [57:0] cx_abs, cy_abs;
    logic [31:0] c_mag, s_mag;
    logic        c_sgn, s_sgn;

    assign ld_mag   = ld_reg[31] ? 32'(-ld_reg) : ld_reg;
    assign rd_mag   = rd_reg[31] ? 32'(-rd_reg) : rd_reg;
    assign dist_mag = dist_reg[56] ? 56'(-dist_reg) : dist_reg[55:0];
    assign cx_abs   = cx_reg[57] ? 58'(-cx_reg) : cx_reg;
    assign cy_abs   = cy_reg[57] ? 58'(-cy_reg) : cy_reg;
    assign c_mag    = cx_abs[31:0];
    assign s_mag    = cy_abs[31:0];
    assign c_sgn    = neg_reg ^ cx_reg[57];
    assign s_sgn    = neg_reg ^ cy_reg[57];

    // shared 32x32 multiplier, product registered
    logic [31:0] mul_a, mul_b;
    always_comb
    begin
        case (cmd.mul_sel)
            odo_pkg::MUL_LEFT:
            begin
                mul_a = ld_mag;
                mul_b = {8'd0, dpt};
            end
            odo_pkg::MUL_RIGHT:
            begin
                mul_a = rd_mag;
                mul_b = {8'd0, dpt};
            end
            odo_pkg::MUL_XHI:
            begin
                mul_a = {6'd0, dist_mag[55:30]};
                mul_b = c_mag;
            end
            odo_pkg::MUL_XLO:
            begin
                mul_a = {2'd0, dist_mag[29:0]};
                mul_b = c_mag;
            end
            odo_pkg::MUL_YHI:
            begin
                mul_a = {6'd0, dist_mag[55:30]};
                mul_b = s_mag;
            end
            odo_pkg::MUL_YLO:
            begin
                mul_a = {2'd0, dist_mag[29:0]};
                mul_b = s_mag;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // signed wheel distances and mean travel
    logic signed [57:0] dsum;
    logic signed [57:0] dsum_adj;
    assign dsum     = 58'(dl_reg) + 58'(dr_reg);
    assign dsum_adj = dsum + {57'd0, dsum[57]};

    always_ff @(posedge clk)
    begin
        if (cmd.dl_load)
        begin
            dl_reg <= ld_reg[31] ? 57'(-$signed({1'b0, prod_reg[55:0]}))
                                 : $signed({1'b0, prod_reg[55:0]});
        end
        if (cmd.dr_load)
        begin
            dr_reg <= rd_reg[31] ? 57'(-$signed({1'b0, prod_reg[55:0]}))
                                 : $signed({1'b0, prod_reg[55:0]});
        end
        if (cmd.setup)
        begin
            dist_reg <= 57'(dsum_adj >>> 1);
        end
    end

    // speed dividends: (125 * |D|) / 32
    logic [55:0] dl_mag, dr_mag;
    logic [62:0] dl_125, dr_125;
    assign dl_mag = dl_reg[56] ? 56'(-dl_reg) : dl_reg[55:0];
    assign dr_mag = dr_reg[56] ? 56'(-dr_reg) : dr_reg[55:0];
    assign dl_125 = {dl_mag, 7'd0} - {6'd0, dl_mag, 1'b0} - {7'd0, dl_mag};
    assign dr_125 = {dr_mag, 7'd0} - {6'd0, dr_mag, 1'b0} - {7'd0, dr_mag};

    logic                        div_done;
    logic [odo_pkg::DIV_W-1:0]   quot_l, quot_r;

    odo_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cmd.setup),
        .dividend_l (dl_125[62:5]),
        .dividend_r (dr_125[62:5]),
        .divisor    (dt_reg),
        .done       (div_done),
        .quot_l     (quot_l),
        .quot_r     (quot_r)
    );

    // cordic iteration terms
    logic signed [57:0] cx_sh, cy_sh;
    logic signed [34:0] atan_v;
    logic [57:0]        norm_m;
    assign cx_sh  = cx_reg >>> cmd.step_idx;
    assign cy_sh  = cy_reg >>> cmd.step_idx;
    assign atan_v = $signed({5'd0, odo_pkg::atan_q30(cmd.step_idx)});
    assign norm_m = (cy_abs > cx_reg[57:0]) ? cy_abs : cx_reg[57:0];

    // heading update
    logic signed [34:0] da, th, th_wrap;
    assign da = (cz_reg + 35'sd2) >>> 2;
    assign th = 35'(theta_prev_reg) + da;
    always_comb
    begin
        th_wrap = th;
        if (th >= odo_pkg::TWO_PI_Q28)
        begin
            th_wrap = th - odo_pkg::TWO_PI_Q28;
        end
        else if (th <= -odo_pkg::TWO_PI_Q28)
        begin
            th_wrap = th + odo_pkg::TWO_PI_Q28;
        end
    end

    // mean heading reduced to [-pi/2, pi/2]
    logic signed [34:0] mean, z1, z2, z3;
    logic               zneg;
    assign mean = (35'(theta_now_reg) + 35'(theta_prev_reg)) <<< 1;
    always_comb
    begin
        z1 = (mean > odo_pkg::PI_Q30) ? mean - odo_pkg::TWO_PI_Q30 : mean;
        z2 = (z1 < -odo_pkg::PI_Q30) ? z1 + odo_pkg::TWO_PI_Q30 : z1;
        z3   = z2;
        zneg = 1'b0;
        if (z2 > odo_pkg::HALF_PI_Q30)
        begin
            z3   = z2 - odo_pkg::PI_Q30;
            zneg = 1'b1;
        end
        else if (z2 < -odo_pkg::HALF_PI_Q30)
        begin
            z3   = z2 + odo_pkg::PI_Q30;
            zneg = 1'b1;
        end
    end

    // shared cordic registers
    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            cy_reg <= 58'(dr_reg) - 58'(dl_reg);
            cx_reg <= $signed({34'd0, wheel_base});
            cz_reg <= '0;
        end
        else if (cmd.norm_shr)
        begin
            cx_reg <= cx_reg >>> 1;
            cy_reg <= cy_reg >>> 1;
        end
        else if (cmd.norm_shl)
        begin
            cx_reg <= cx_reg <<< 1;
            cy_reg <= cy_reg <<< 1;
        end
        else if (cmd.vec_step)
        begin
            if (!cy_reg[57] && (cy_reg != '0))
            begin
                cx_reg <= cx_reg + cy_sh;
                cy_reg <= cy_reg - cx_sh;
                cz_reg <= cz_reg + atan_v;
            end
            else
            begin
                cx_reg <= cx_reg - cy_sh;
                cy_reg <= cy_reg + cx_sh;
                cz_reg <= cz_reg - atan_v;
            end
        end
        else if (cmd.rot_init)
        begin
            cx_reg  <= odo_pkg::GAIN_Q30;
            cy_reg  <= '0;
            cz_reg  <= z3;
            neg_reg <= zneg;
        end
        else if (cmd.rot_step)
        begin
            if (!cz_reg[34])
            begin
                cx_reg <= cx_reg - cy_sh;
                cy_reg <= cy_reg + cx_sh;
                cz_reg <= cz_reg - atan_v;
            end
            else
            begin
                cx_reg <= cx_reg + cy_sh;
                cy_reg <= cy_reg - cx_sh;
                cz_reg <= cz_reg + atan_v;
            end
        end
    end

    // heading state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            theta_now_reg  <= '0;
            theta_prev_reg <= '0;
        end
        else
        begin
            if (cmd.head_update)
            begin
                theta_now_reg <= th_wrap[31:0];
            end
            if (cmd.rot_init)
            begin
                theta_prev_reg <= theta_now_reg;
            end
        end
    end

    // partial product sum of one q30 multiply
    always_ff @(posedge clk)
    begin
        if (cmd.part_load)
        begin
            part_reg <= prod_reg[58:0];
        end
        else if (cmd.part_add)
        begin
            part_reg <= part_reg + {25'd0, prod_reg[63:30]};
        end
    end

    // position accumulators, wrapping at 48 bits
    logic        dx_neg, dy_neg;
    logic [47:0] step48;
    assign dx_neg = dist_reg[56] ^ c_sgn;
    assign dy_neg = dist_reg[56] ^ s_sgn;
    assign step48 = part_reg[47:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_acc_reg <= '0;
            y_acc_reg <= '0;
        end
        else
        begin
            if (cmd.acc_x)
            begin
                x_acc_reg <= dx_neg ? x_acc_reg - $signed(step48)
                                    : x_acc_reg + $signed(step48);
            end
            if (cmd.acc_y)
            begin
                y_acc_reg <= dy_neg ? y_acc_reg - $signed(step48)
                                    : y_acc_reg + $signed(step48);
            end
        end
    end

    // saturated speeds, truncated toward zero
    function automatic logic signed [31:0] sat_speed(input logic neg,
                                                     input logic [odo_pkg::DIV_W-1:0] q);
        logic signed [31:0] r;
        if (!neg)
        begin
            r = (q > 58'd2147483647) ? 32'sh7FFFFFFF : $signed(q[31:0]);
        end
        else
        begin
            r = (q > 58'd2147483648) ? 32'sh80000000 : $signed(32'(-q[31:0]));
        end
        return r;
    endfunction

    logic zero_dt;
    assign zero_dt = (dt_reg == '0);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.left_speed    <= zero_dt ? '0 : sat_speed(dl_reg[56], quot_l);
            out_reg.right_speed   <= zero_dt ? '0 : sat_speed(dr_reg[56], quot_r);
            out_reg.pos_x         <= x_acc_reg;
            out_reg.pos_y         <= y_acc_reg;
            out_reg.heading       <= theta_now_reg;
            out_reg.zero_interval <= zero_dt;
        end
    end

    assign res       = out_reg;
    assign res_valid = out_valid_reg;

    // status back to the sequencer
    assign status.y_zero     = (cy_reg == '0);
    assign status.norm_big   = (norm_m[57:41] != '0);
    assign status.norm_small = (norm_m[57:40] == '0);
    assign status.div_done   = div_done;
    assign status.out_free   = !out_valid_reg || res_ready;
endmodule

### rtl/differential_drive_odometry.sv
// top level of the differential-drive odometry block
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    left_count, right_count, time_ms
//  out_ch    out  valid/ready    left_speed, right_speed, pos_x, pos_y, heading,
//                                zero_interval
//  apb       in   psel/penable   tick scale at 0x0, wheel_base at 0x4
//
// one transaction at a time; before the vectoring pass the atan2 operands are normalised
// by shifts of one bit per cycle; equal wheel travels skip the vectoring pass altogether
// the speed divider starts in the setup state and runs beside the cordic passes
// reset clears pose, previous sample and configuration to their defaults
// a finished result waits in the output register; the next transaction is taken meanwhile,
// and a result still waiting holds the sequencer in its last state
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    odo_in_if.sink        in_ch,
    odo_out_if.source     out_ch,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    logic [odo_pkg::CFG_W-1:0] dpt_reg, wb_reg;
    logic                      wr_en;
    odo_pkg::reg_idx_t         reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = odo_pkg::reg_idx_t'(paddr[2]);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpt_reg <= 24'd65536;
            wb_reg  <= 24'd4194304;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                odo_pkg::REG_DPT: dpt_reg <= pwdata[odo_pkg::CFG_W-1:0];
                odo_pkg::REG_WB:  wb_reg  <= pwdata[odo_pkg::CFG_W-1:0];
                default:          dpt_reg <= dpt_reg;
            endcase
        end
    end

    // read-back
    always_comb
    begin
        case (reg_sel)
            odo_pkg::REG_DPT: prdata = {8'd0, dpt_reg};
            odo_pkg::REG_WB:  prdata = {8'd0, wb_reg};
            default:          prdata = '0;
        endcase
    end

    odo_pkg::cmd_t    cmd;
    odo_pkg::status_t status;
    odo_pkg::res_t    res;
    logic             res_valid;

    odo_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    odo_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .left_count  (in_ch.left_count),
        .right_count (in_ch.right_count),
        .time_ms     (in_ch.time_ms),
        .dpt         (dpt_reg),
        .wheel_base  (wb_reg),
        .res         (res),
        .res_valid   (res_valid),
        .res_ready   (out_ch.ready)
    );

    // result channel
    assign out_ch.valid         = res_valid;
    assign out_ch.left_speed    = res.left_speed;
    assign out_ch.right_speed   = res.right_speed;
    assign out_ch.pos_x         = res.pos_x;
    assign out_ch.pos_y         = res.pos_y;
    assign out_ch.heading       = res.heading;
    assign out_ch.zero_interval = res.zero_interval;
endmodule

### rtl/odo_checker.sv
// port-level checks for the odometry block, bound to the top level
module odo_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] left_speed,
    input logic signed [31:0] right_speed,
    input logic signed [47:0] pos_x,
    input logic signed [31:0] heading,
    input logic               zero_interval
);
    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its x position and heading
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pos_x) && $stable(heading))
        else $error("result changed while stalled");

    // one transaction in flight at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while busy");

    // zero interval forces zero speeds
    a_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_interval |-> left_speed == 0 && right_speed == 0)
        else $error("speed non-zero with zero interval");

    // heading stays inside the open two-pi range
    a_heading: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> heading < 32'sd1686629713 && heading > -32'sd1686629713)
        else $error("heading out of range");
endmodule

bind differential_drive_odometry odo_checker u_odo_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .left_speed    (out_ch.left_speed),
    .right_speed   (out_ch.right_speed),
    .pos_x         (out_ch.pos_x),
    .heading       (out_ch.heading),
    .zero_interval (out_ch.zero_interval)
);
